// ===== hw/rtl/plta_pkg.sv =====
package plta_pkg;

	// counter width default, handed to the top level parameter
	localparam int COUNTER_BITS_DEF = 32;

	// fixed field widths
	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 32;
	localparam int AHEAD_W  = 16;
	localparam int PERIOD_W = 16;
	localparam int OUT_W    = 32;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd256;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK          = 3'd0,
		ACT_STRETCH_BEGIN = 3'd1,
		ACT_STRETCH_END   = 3'd2,
		ACT_ONE_SHOT      = 3'd3,
		ACT_REANCHOR      = 3'd4
	} action_t;

endpackage

// ===== hw/rtl/plta_if.sv =====
interface plta_evt_if import plta_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [VALUE_W-1:0]  counter_value;
	logic [AHEAD_W-1:0]  stretch_ticks;
	logic                counting_ok;

	modport source (output valid, action, counter_value, stretch_ticks, counting_ok,
		input ready);
	modport sink (input valid, action, counter_value, stretch_ticks, counting_ok,
		output ready);
endinterface

interface plta_res_if import plta_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] ticks_credited;
	logic             arm_valid;
	logic [OUT_W-1:0] compare_delta;
	logic             accepted;

	modport source (output valid, ticks_credited, arm_valid, compare_delta, accepted,
		input ready);
	modport sink (input valid, ticks_credited, arm_valid, compare_delta, accepted,
		output ready);
endinterface

interface plta_cfg_if import plta_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PERIOD_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/plta_div.sv =====
// Restoring divider, one quotient bit per cycle.
module plta_div import plta_pkg::*; #(
	parameter int W = COUNTER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        dividend,
	input  logic [PERIOD_W-1:0] divisor,
	output logic                busy,
	output logic                done,
	output logic [W-1:0]        quotient,
	output logic [PERIOD_W-1:0] remainder
);

	localparam int CNT_W = $clog2(W);

	logic [W-1:0]        quo_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic                fits;
	logic [PERIOD_W-1:0] rem_next;

	// partial remainder stays below the divisor, so 17 bits cover the trial
	assign trial    = {rem_q, quo_q[W-1]};
	assign diff     = trial - {1'b0, divisor};
	assign fits     = ~diff[PERIOD_W];
	assign rem_next = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/plta_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module plta_mul import plta_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [PERIOD_W-1:0]          mcand,
	input  logic [AHEAD_W-1:0]           mplr,
	output logic                         busy,
	output logic                         done,
	output logic [PERIOD_W+AHEAD_W-1:0]  product
);

	localparam int PROD_W = PERIOD_W + AHEAD_W;
	localparam int CNT_W  = $clog2(AHEAD_W);

	logic [PROD_W-1:0]  mcand_q;
	logic [AHEAD_W-1:0] mplr_q;
	logic [PROD_W-1:0]  acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= PROD_W'(mcand);
			mplr_q  <= mplr;
			acc_q   <= '0;
		end else if (busy_q) begin
			if (mplr_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
			mplr_q  <= {1'b0, mplr_q[AHEAD_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(AHEAD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== hw/rtl/phase_locked_tick_accountant.sv =====
// Events that credit ticks run the serial divider (one quotient bit per cycle), a
// stretch begin runs the 16-step serial multiply, and all other events go straight
// to the output register.
// One event at a time; the next is taken the cycle after the result is loaded into
// the output register.
// Reset (arst_n low, asynchronous): tick_period = 256, anchor = 0, no stretch open.
module phase_locked_tick_accountant import plta_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	plta_evt_if.sink   evt,
	plta_res_if.source res,
	plta_cfg_if.sink   cfg
);

	localparam int CB = COUNTER_BITS;

	// one-hot sequencer
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_BUSY = 3'b010,
		ST_PUSH = 3'b100
	} state_t;

	// decoded event: which engine runs and how the state moves
	typedef struct packed {
		logic do_div;        // credit whole ticks
		logic do_mul;        // stretch span
		logic arm;
		logic close_stretch;
		logic open_stretch;
		logic reanchor;
		logic refused;
	} op_t;

	state_t              state_q;
	op_t                 op_d;
	op_t                 op_q;
	logic [PERIOD_W-1:0] tick_period_q;
	logic [CB-1:0]       tick_anchor_q;
	logic                stretch_open_q;
	logic [CB-1:0]       now_q;
	logic [CB-1:0]       elapsed_q;

	logic                evt_fire;
	logic                push;
	logic [CB-1:0]       elapsed_d;

	// output register
	logic                res_valid_q;
	logic [OUT_W-1:0]    res_credited_q;
	logic                res_arm_q;
	logic [OUT_W-1:0]    res_delta_q;
	logic                res_accepted_q;

	// engines
	logic                div_busy;
	logic                div_done;
	logic [CB-1:0]       div_quo;
	logic [PERIOD_W-1:0] div_rem;
	logic                mul_busy;
	logic                mul_done;
	logic [OUT_W-1:0]    mul_prod;

	logic [OUT_W-1:0]    credited;
	logic [OUT_W-1:0]    delta;
	logic [OUT_W-1:0]    into_ext;

	assign evt_fire  = evt.valid && evt.ready;
	assign evt.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// wrapping distance from the anchor, low COUNTER_BITS of the sample only
	assign elapsed_d = evt.counter_value[CB-1:0] - tick_anchor_q;

	always_comb begin
		op_d = '0;
		case (evt.action)
			ACT_TICK: begin
				op_d.do_div        = 1'b1;
				op_d.arm           = 1'b1;
				op_d.close_stretch = 1'b1;
			end
			ACT_STRETCH_BEGIN: begin
				if (evt.counting_ok) begin
					op_d.do_mul       = 1'b1;
					op_d.arm          = 1'b1;
					op_d.open_stretch = 1'b1;
				end else begin
					op_d.refused = 1'b1;
				end
			end
			ACT_STRETCH_END: begin
				// no stretch open: nothing is credited or armed
				if (stretch_open_q) begin
					op_d.do_div        = 1'b1;
					op_d.arm           = 1'b1;
					op_d.close_stretch = 1'b1;
				end
			end
			ACT_ONE_SHOT: begin
				// credits only inside a stretch, never arms
				op_d.do_div = stretch_open_q;
			end
			ACT_REANCHOR: begin
				op_d.reanchor      = 1'b1;
				op_d.arm           = 1'b1;
				op_d.close_stretch = 1'b1;
			end
			default: begin
				op_d = '0;
			end
		endcase
	end

	plta_div #(
		.W (CB)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (evt_fire && op_d.do_div),
		.dividend  (elapsed_d),
		.divisor   (tick_period_q),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	plta_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (evt_fire && op_d.do_mul),
		.mcand   (tick_period_q),
		.mplr    (evt.stretch_ticks),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_prod)
	);

	// result is loaded once the output register is free or being drained
	assign push = (state_q == ST_PUSH) && (!res_valid_q || res.ready);

	// The remainder of the divide is exactly the phase left after crediting, so the
	// new anchor is now - rem and the boundary delta is period - rem (always >= 1).
	assign into_ext = OUT_W'(elapsed_q);
	assign credited = op_q.do_div ? OUT_W'(div_quo) : '0;

	always_comb begin
		delta = '0;
		if (op_q.reanchor) begin
			delta = OUT_W'(tick_period_q);
		end else if (op_q.do_mul) begin
			// stretch target, not reduced to the counter width
			delta = (mul_prod > into_ext) ? (mul_prod - into_ext) : OUT_W'(1);
		end else if (op_q.do_div && op_q.arm) begin
			delta = OUT_W'(tick_period_q - div_rem);
		end
	end

	// event payload capture
	always_ff @(posedge clk) begin
		if (evt_fire) begin
			now_q     <= evt.counter_value[CB-1:0];
			elapsed_q <= elapsed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_credited_q <= credited;
			res_arm_q      <= op_q.arm;
			res_delta_q    <= delta;
			res_accepted_q <= !op_q.refused;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= '0;
			tick_period_q  <= PERIOD_RESET;
			tick_anchor_q  <= '0;
			stretch_open_q <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			// zero period is floored to one
			if (cfg.valid && cfg.ready) begin
				tick_period_q <= (cfg.data == '0) ? PERIOD_W'(1) : cfg.data;
			end

			if (push) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (evt_fire) begin
						op_q    <= op_d;
						state_q <= (op_d.do_div || op_d.do_mul) ? ST_BUSY : ST_PUSH;
					end
				end
				ST_BUSY: begin
					if ((op_q.do_div && div_done) || (op_q.do_mul && mul_done)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push) begin
						// commit state with the transaction
						if (op_q.reanchor) begin
							tick_anchor_q <= now_q;
						end else if (op_q.do_div) begin
							tick_anchor_q <= now_q - CB'(div_rem);
						end
						if (op_q.close_stretch) begin
							stretch_open_q <= 1'b0;
						end else if (op_q.open_stretch) begin
							stretch_open_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid          = res_valid_q;
	assign res.ticks_credited = res_credited_q;
	assign res.arm_valid      = res_arm_q;
	assign res.compare_delta  = res_delta_q;
	assign res.accepted       = res_accepted_q;

`ifndef SYNTHESIS
	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tick_period_q != '0)
		else $error("tick period is zero");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (div_rem < tick_period_q))
		else $error("divider remainder not below period");

	a_idle_engines: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!div_busy && !mul_busy))
		else $error("engine running while idle");

	a_refused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.accepted) |-> (!res.arm_valid && res.ticks_credited == '0))
		else $error("refused stretch armed or credited");

	a_arm_delta: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.arm_valid) |-> (res.compare_delta != '0))
		else $error("armed with zero delta");
`endif

endmodule
